// ===== rtl/c8de_pkg.sv =====
// ----------------------------------------------------------------------------
// c8de_pkg
// shared types, opcode table and codes for the chip-8 decode/execute block
// ----------------------------------------------------------------------------
package c8de_pkg;

  localparam int NUM_OPS     = 35;
  localparam int OP_W        = 6;
  localparam int WORD_W      = 16;
  localparam int ADDR_W      = 12;
  localparam int DATA_W      = 8;
  localparam int VREG_NUM    = 16;
  localparam int VIDX_W      = $clog2(VREG_NUM);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] START_RESET = 12'h200;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_RET  = 6'd1;
  localparam op_t OP_CALL = 6'd3;
  localparam op_t OP_SEI  = 6'd4;
  localparam op_t OP_LDI  = 6'd7;
  localparam op_t OP_ADDI = 6'd8;
  localparam op_t OP_LDA  = 6'd19;
  localparam op_t OP_NONE = 6'd35;

  typedef enum logic [2:0] {
    ST_OK  = 3'd0,
    ST_ILL = 3'd1,
    ST_UF  = 3'd2,
    ST_OF  = 3'd3,
    ST_NI  = 3'd4
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    op_t               op;
  } item_t;

  localparam logic [WORD_W-1:0] OP_FILTER [NUM_OPS] = '{
    16'h00E0, 16'h00EE, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h5000,
    16'h6000, 16'h7000, 16'h8000, 16'h8001, 16'h8002, 16'h8003, 16'h8004,
    16'h8005, 16'h8006, 16'h8007, 16'h800E, 16'h9000, 16'hA000, 16'hB000,
    16'hC000, 16'hD000, 16'hE09E, 16'hE0A1, 16'hF007, 16'hF00A, 16'hF015,
    16'hF018, 16'hF01E, 16'hF029, 16'hF033, 16'hF055, 16'hF065, 16'h0000
  };

  localparam logic [WORD_W-1:0] OP_MASK [NUM_OPS] = '{
    16'hFFFF, 16'hFFFF, 16'hF000, 16'hF000, 16'hF000, 16'hF000, 16'hF00F,
    16'hF000, 16'hF000, 16'hF00F, 16'hF00F, 16'hF00F, 16'hF00F, 16'hF00F,
    16'hF00F, 16'hF00F, 16'hF00F, 16'hF00F, 16'hF00F, 16'hF000, 16'hF000,
    16'hF000, 16'hF000, 16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF0FF,
    16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF0FF, 16'hF000
  };

endpackage

// ===== rtl/c8de_front.sv =====
// ----------------------------------------------------------------------------
// c8de_front
// input handshake and opcode classification against the table
// ----------------------------------------------------------------------------
module c8de_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [c8de_pkg::WORD_W-1:0]    instruction_word,
  input  logic                           queue_full,
  output logic                           push,
  output c8de_pkg::item_t                push_item
);
  import c8de_pkg::*;

  op_t op;

  // first match in table order wins
  always_comb begin
    op = OP_NONE;
    for (int i = NUM_OPS - 1; i >= 0; i--) begin
      if ((instruction_word & OP_MASK[i]) == OP_FILTER[i]) begin
        op = OP_W'(i);
      end
    end
  end

  assign in_stall       = queue_full;
  assign push           = in_valid && !queue_full;
  assign push_item.word = instruction_word;
  assign push_item.op   = op;

endmodule

// ===== rtl/c8de_queue.sv =====
// ----------------------------------------------------------------------------
// c8de_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module c8de_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  c8de_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output c8de_pkg::item_t head_item
);
  import c8de_pkg::*;

  item_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_next;
  logic [QPTR_W-1:0]   rd_ptr_next;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  assign wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/c8de_back.sv =====
// ----------------------------------------------------------------------------
// c8de_back
// executes classified beats against machine state, registers the result
// ----------------------------------------------------------------------------
module c8de_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [c8de_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            head_valid,
  input  c8de_pkg::item_t                 head_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [c8de_pkg::OP_W-1:0]       decoded_op,
  output logic [c8de_pkg::ADDR_W-1:0]     next_pc,
  output logic [c8de_pkg::ADDR_W-1:0]     index_value,
  output logic                            reg_write_valid,
  output logic [c8de_pkg::VIDX_W-1:0]     reg_write_index,
  output logic [c8de_pkg::DATA_W-1:0]     reg_write_value,
  output logic [c8de_pkg::SP_W-1:0]       stack_depth
);
  import c8de_pkg::*;

  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index_reg;
  logic [SP_W-1:0]   sp;
  logic [DATA_W-1:0] vregs  [VREG_NUM];
  logic [ADDR_W-1:0] rstack [STACK_DEPTH];

  logic [VIDX_W-1:0] x;
  logic [DATA_W-1:0] kk;
  logic [ADDR_W-1:0] nnn;
  logic [DATA_W-1:0] vx;
  logic [SP_W-1:0]   sp_m1;
  logic [ADDR_W-1:0] ret_addr;
  logic [ADDR_W-1:0] pc2;
  logic [ADDR_W-1:0] pc4;

  status_t           st;
  logic [ADDR_W-1:0] pc_next;
  logic [ADDR_W-1:0] index_next;
  logic [SP_W-1:0]   sp_next;
  logic              wr_v;
  logic [VIDX_W-1:0] wr_i;
  logic [DATA_W-1:0] wr_d;
  logic              stack_push;
  logic              fire;
  logic              commit;

  assign x        = head_item.word[11:8];
  assign kk       = head_item.word[7:0];
  assign nnn      = head_item.word[11:0];
  assign vx       = vregs[x];
  assign sp_m1    = sp - 1'b1;
  assign ret_addr = rstack[sp_m1[SIDX_W-1:0]];
  assign pc2      = pc + ADDR_W'(2);
  assign pc4      = pc + ADDR_W'(4);

  always_comb begin
    st         = ST_OK;
    pc_next    = pc;
    index_next = index_reg;
    sp_next    = sp;
    wr_v       = 1'b0;
    wr_i       = '0;
    wr_d       = '0;
    stack_push = 1'b0;
    case (head_item.op)
      OP_NONE: begin
        st = ST_ILL;
      end
      OP_RET: begin
        if (sp == '0) begin
          st = ST_UF;
        end else begin
          sp_next = sp_m1;
          pc_next = ret_addr;
        end
      end
      OP_CALL: begin
        if (sp >= SP_W'(STACK_DEPTH)) begin
          st = ST_OF;
        end else begin
          stack_push = 1'b1;
          sp_next    = sp + 1'b1;
          pc_next    = nnn;
        end
      end
      OP_SEI: begin
        pc_next = (vx == kk) ? pc4 : pc2;
      end
      OP_LDI: begin
        wr_v    = 1'b1;
        wr_i    = x;
        wr_d    = kk;
        pc_next = pc2;
      end
      OP_ADDI: begin
        wr_v    = 1'b1;
        wr_i    = x;
        wr_d    = vx + kk;
        pc_next = pc2;
      end
      OP_LDA: begin
        index_next = nnn;
        pc_next    = pc2;
      end
      default: begin
        st = ST_NI;
      end
    endcase
  end

  assign fire   = head_valid && (!out_valid || !out_stall);
  assign pop    = fire;
  assign commit = fire && (st == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= START_RESET;
      index_reg <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < VREG_NUM; i++) begin
        vregs[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        pc <= cfg_data;
      end else if (commit) begin
        pc <= pc_next;
      end
      if (commit) begin
        index_reg <= index_next;
        sp        <= sp_next;
        if (wr_v) begin
          vregs[wr_i] <= wr_d;
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // return stack, no reset: entries below sp are always written first
  always_ff @(posedge clk) begin
    if (commit && stack_push) begin
      rstack[sp[SIDX_W-1:0]] <= pc2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      status          <= st;
      decoded_op      <= head_item.op;
      next_pc         <= (st == ST_OK) ? pc_next : pc;
      index_value     <= (st == ST_OK) ? index_next : index_reg;
      reg_write_valid <= wr_v;
      reg_write_index <= wr_i;
      reg_write_value <= wr_d;
      stack_depth     <= (st == ST_OK) ? sp_next : sp;
    end
  end

endmodule

// ===== rtl/chip8_decode_execute_subset_top.sv =====
// ----------------------------------------------------------------------------
// chip8_decode_execute_subset_top
// chip-8 instruction decode and execute of the load/add/skip/index/call/return
// subset, with a decode front end and an execute back end joined by a queue
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    instruction_word
//  out      out_valid / out_stall  status, decoded_op, next_pc, index_value,
//                                  reg_write_valid/index/value, stack_depth
//  config   cfg_write              cfg_data (start address, also loads pc)
//
//  one instruction per cycle sustained while out_stall is low; the execute
//  state loop closes combinationally; a result beat is queued, then registered.
//  synchronous reset: pc = 0x200, registers, index and stack pointer cleared.
//  in_stall rises only when the two-entry queue is full; an output stall
//  holds the result register and backs up into the queue.
// ----------------------------------------------------------------------------
module chip8_decode_execute_subset_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [c8de_pkg::ADDR_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [c8de_pkg::WORD_W-1:0]     instruction_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [c8de_pkg::OP_W-1:0]       decoded_op,
  output logic [c8de_pkg::ADDR_W-1:0]     next_pc,
  output logic [c8de_pkg::ADDR_W-1:0]     index_value,
  output logic                            reg_write_valid,
  output logic [c8de_pkg::VIDX_W-1:0]     reg_write_index,
  output logic [c8de_pkg::DATA_W-1:0]     reg_write_value,
  output logic [c8de_pkg::SP_W-1:0]       stack_depth
);
  import c8de_pkg::*;

  logic  queue_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  c8de_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .instruction_word (instruction_word),
    .queue_full       (queue_full),
    .push             (push),
    .push_item        (push_item)
  );

  c8de_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  c8de_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .decoded_op      (decoded_op),
    .next_pc         (next_pc),
    .index_value     (index_value),
    .reg_write_valid (reg_write_valid),
    .reg_write_index (reg_write_index),
    .reg_write_value (reg_write_value),
    .stack_depth     (stack_depth)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chip-8 decode/execute subset block. a scoreboard
// carries its own copy of pc, data registers, index and return stack, decodes
// every accepted instruction and queues the expected result beat. it compares
// each output beat field by field. stimulus is a short directed set, then
// random programs under several start addresses, with bursty input and a
// shifting output stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c8de_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int RUN_LIMIT    = 200000;
  localparam int MAX_REPORTS  = 10;

  // decode table positions not named in the package
  localparam op_t OP_CLS     = 6'd0;
  localparam op_t OP_JP      = 6'd2;
  localparam op_t OP_SNE     = 6'd5;
  localparam op_t OP_SE_VV   = 6'd6;
  localparam op_t OP_ALU0    = 6'd9;
  localparam op_t OP_SHL     = 6'd17;
  localparam op_t OP_SNE_VV  = 6'd18;
  localparam op_t OP_JP_V0   = 6'd20;
  localparam op_t OP_RND     = 6'd21;
  localparam op_t OP_DRW     = 6'd22;
  localparam op_t OP_SKP     = 6'd23;
  localparam op_t OP_SKNP    = 6'd24;
  localparam op_t OP_LD_VDT  = 6'd25;
  localparam op_t OP_LD_K    = 6'd26;
  localparam op_t OP_LD_DT   = 6'd27;
  localparam op_t OP_LD_ST   = 6'd28;
  localparam op_t OP_ADD_IV  = 6'd29;
  localparam op_t OP_LD_F    = 6'd30;
  localparam op_t OP_LD_B    = 6'd31;
  localparam op_t OP_LD_MEM  = 6'd32;
  localparam op_t OP_LD_REG  = 6'd33;
  localparam op_t OP_SYS     = 6'd34;

  localparam logic [3:0] NIB_CALL = 4'h2;
  localparam logic [3:0] NIB_SE   = 4'h3;
  localparam logic [3:0] NIB_LD   = 4'h6;
  localparam logic [3:0] NIB_ADD  = 4'h7;
  localparam logic [3:0] NIB_LDA  = 4'hA;
  localparam logic [WORD_W-1:0] W_RET = 16'h00EE;

  // one sample of every table entry that is decoded but not executed
  localparam int N_UNIMPL = 29;
  localparam logic [WORD_W-1:0] UNIMPL_WORDS [N_UNIMPL] = '{
    16'h00E0, 16'h0123, 16'h1234, 16'h4123, 16'h5120, 16'h8120, 16'h8121,
    16'h8122, 16'h8123, 16'h8124, 16'h8125, 16'h8126, 16'h8127, 16'h812E,
    16'h9120, 16'hB123, 16'hC123, 16'hD123, 16'hE19E, 16'hE1A1, 16'hF107,
    16'hF10A, 16'hF115, 16'hF118, 16'hF11E, 16'hF129, 16'hF133, 16'hF155,
    16'hF165
  };

  // extremes and encodings that fall outside the table
  localparam int N_EDGE_WORDS = 8;
  localparam logic [WORD_W-1:0] EDGE_WORDS [N_EDGE_WORDS] = '{
    16'h0000, 16'h0FFF, 16'hFFFF, 16'h5AB1, 16'h8AB8, 16'h9ABF, 16'hE0A2,
    16'hF0FF
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    status_t              status;
    op_t                  op;
    logic [ADDR_W-1:0]    pc;
    logic [ADDR_W-1:0]    idx;
    logic                 wr_valid;
    logic [VIDX_W-1:0]    wr_index;
    logic [DATA_W-1:0]    wr_value;
    logic [SP_W-1:0]      depth;
  } c8_result_t;

  class c8_scoreboard;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] index_reg;
    logic [DATA_W-1:0] vreg [VREG_NUM];
    logic [SP_W-1:0]   sp;
    logic [ADDR_W-1:0] ret_stack [STACK_DEPTH];
    c8_result_t        expected_q [$];
    int                mismatches;
    int                checked;
    int                status_count [5];
    bit [NUM_OPS:0]    ops_seen;

    function new();
      pc = START_RESET;
      index_reg = '0;
      sp = '0;
      foreach (vreg[i]) vreg[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
      foreach (status_count[i]) status_count[i] = 0;
      mismatches = 0;
      checked = 0;
      ops_seen = '0;
    endfunction

    function void load_start(logic [ADDR_W-1:0] a);
      pc = a;
    endfunction

    function op_t decode(logic [WORD_W-1:0] w);
      op_t op;
      op = OP_NONE;
      casez (w)
        16'h00E0: op = OP_CLS;
        16'h00EE: op = OP_RET;
        16'h0???: op = OP_SYS;
        16'h1???: op = OP_JP;
        16'h2???: op = OP_CALL;
        16'h3???: op = OP_SEI;
        16'h4???: op = OP_SNE;
        16'h5??0: op = OP_SE_VV;
        16'h6???: op = OP_LDI;
        16'h7???: op = OP_ADDI;
        16'h8???: begin
          if (w[3:0] <= 4'h7) op = op_t'(OP_ALU0 + w[3:0]);
          else if (w[3:0] == 4'hE) op = OP_SHL;
        end
        16'h9??0: op = OP_SNE_VV;
        16'hA???: op = OP_LDA;
        16'hB???: op = OP_JP_V0;
        16'hC???: op = OP_RND;
        16'hD???: op = OP_DRW;
        16'hE?9E: op = OP_SKP;
        16'hE?A1: op = OP_SKNP;
        16'hF?07: op = OP_LD_VDT;
        16'hF?0A: op = OP_LD_K;
        16'hF?15: op = OP_LD_DT;
        16'hF?18: op = OP_LD_ST;
        16'hF?1E: op = OP_ADD_IV;
        16'hF?29: op = OP_LD_F;
        16'hF?33: op = OP_LD_B;
        16'hF?55: op = OP_LD_MEM;
        16'hF?65: op = OP_LD_REG;
        default:  op = OP_NONE;
      endcase
      return op;
    endfunction

    function void note_instruction(logic [WORD_W-1:0] w);
      c8_result_t        r;
      logic [ADDR_W-1:0] pc_plus2;
      logic [VIDX_W-1:0] x;
      logic [DATA_W-1:0] kk;
      r = '0;
      x = w[11:8];
      kk = w[7:0];
      pc_plus2 = pc + ADDR_W'(2);
      r.op = decode(w);
      r.status = ST_ILL;
      if (r.op != OP_NONE) begin
        r.status = ST_OK;
        case (r.op)
          OP_RET: begin
            if (sp == '0) begin
              r.status = ST_UF;
            end else begin
              sp = sp - 1'b1;
              pc = ret_stack[sp[SIDX_W-1:0]];
            end
          end
          OP_CALL: begin
            if (sp >= SP_W'(STACK_DEPTH)) begin
              r.status = ST_OF;
            end else begin
              ret_stack[sp[SIDX_W-1:0]] = pc_plus2;
              sp = sp + 1'b1;
              pc = w[11:0];
            end
          end
          OP_SEI: pc = (vreg[x] == kk) ? pc + ADDR_W'(4) : pc_plus2;
          OP_LDI: begin
            vreg[x] = kk;
            r.wr_valid = 1'b1;
            r.wr_index = x;
            r.wr_value = kk;
            pc = pc_plus2;
          end
          OP_ADDI: begin
            vreg[x] = vreg[x] + kk;
            r.wr_valid = 1'b1;
            r.wr_index = x;
            r.wr_value = vreg[x];
            pc = pc_plus2;
          end
          OP_LDA: begin
            index_reg = w[11:0];
            pc = pc_plus2;
          end
          default: r.status = ST_NI;
        endcase
      end
      r.pc = pc;
      r.idx = index_reg;
      r.depth = sp;
      expected_q.push_back(r);
    endfunction

    function void check_result(c8_result_t got);
      c8_result_t exp;
      string      diffs;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: status %0d op %0d pc %03h", got.status, got.op, got.pc);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      diffs = "";
      if (got.status !== exp.status)
        diffs = {diffs, $sformatf(" status exp %0d got %0d", exp.status, got.status)};
      if (got.op !== exp.op)
        diffs = {diffs, $sformatf(" op exp %0d got %0d", exp.op, got.op)};
      if (got.pc !== exp.pc)
        diffs = {diffs, $sformatf(" pc exp %03h got %03h", exp.pc, got.pc)};
      if (got.idx !== exp.idx)
        diffs = {diffs, $sformatf(" index exp %03h got %03h", exp.idx, got.idx)};
      if (got.wr_valid !== exp.wr_valid)
        diffs = {diffs, $sformatf(" wr_valid exp %0b got %0b", exp.wr_valid, got.wr_valid)};
      if (got.wr_index !== exp.wr_index)
        diffs = {diffs, $sformatf(" wr_index exp %0d got %0d", exp.wr_index, got.wr_index)};
      if (got.wr_value !== exp.wr_value)
        diffs = {diffs, $sformatf(" wr_value exp %02h got %02h", exp.wr_value, got.wr_value)};
      if (got.depth !== exp.depth)
        diffs = {diffs, $sformatf(" depth exp %0d got %0d", exp.depth, got.depth)};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch on beat %0d:%s", checked, diffs);
      end
      status_count[exp.status]++;
      ops_seen[exp.op] = 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [ADDR_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [WORD_W-1:0]   instruction_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          status;
  logic [OP_W-1:0]     decoded_op;
  logic [ADDR_W-1:0]   next_pc;
  logic [ADDR_W-1:0]   index_value;
  logic                reg_write_valid;
  logic [VIDX_W-1:0]   reg_write_index;
  logic [DATA_W-1:0]   reg_write_value;
  logic [SP_W-1:0]     stack_depth;

  c8_scoreboard sb = new();
  int           cycle_count = 0;
  int           items_sent = 0;
  int           starts_written = 0;
  int           burst_left = 4;
  int           stall_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;

  chip8_decode_execute_subset_top DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .instruction_word(instruction_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .decoded_op      (decoded_op),
    .next_pc         (next_pc),
    .index_value     (index_value),
    .reg_write_valid (reg_write_valid),
    .reg_write_index (reg_write_index),
    .reg_write_value (reg_write_value),
    .stack_depth     (stack_depth)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin : monitor
    c8_result_t beat;
    if (!rst) begin
      if (cfg_write) sb.load_start(cfg_data);
      if (in_valid && !in_stall) sb.note_instruction(instruction_word);
      if (out_valid && !out_stall) begin
        beat.status   = status_t'(status);
        beat.op       = decoded_op;
        beat.pc       = next_pc;
        beat.idx      = index_value;
        beat.wr_valid = reg_write_valid;
        beat.wr_index = reg_write_index;
        beat.wr_value = reg_write_value;
        beat.depth    = stack_depth;
        sb.check_result(beat);
      end
    end
  end

  task automatic drive_word(input logic [WORD_W-1:0] w);
    in_valid <= 1'b1;
    instruction_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic go_idle();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [ADDR_W-1:0] a);
    go_idle();
    cfg_write <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_write <= 1'b0;
    starts_written++;
  endtask

  task automatic run_random(input int count);
    int                target;
    int                pick;
    int                depth;
    logic [VIDX_W-1:0] x;
    logic [WORD_W-1:0] w;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      x = VIDX_W'($urandom_range(0, VREG_NUM - 1));
      if (pick < 22) begin
        drive_word({NIB_LD, x, 8'($urandom_range(0, 255))});
      end else if (pick < 40) begin
        drive_word({NIB_ADD, x, 8'($urandom_range(0, 255))});
      end else if (pick < 52) begin
        // half the skips compare against the value the register holds now
        if ($urandom_range(0, 1) == 0) drive_word({NIB_SE, x, sb.vreg[x]});
        else drive_word({NIB_SE, x, 8'($urandom_range(0, 255))});
      end else if (pick < 60) begin
        drive_word({NIB_LDA, 12'($urandom_range(0, 4095))});
      end else if (pick < 71) begin
        drive_word({NIB_CALL, 12'($urandom_range(0, 4095))});
      end else if (pick < 82) begin
        drive_word(W_RET);
      end else if (pick < 85) begin
        // nested calls from just under to past the stack depth, then as many returns or up to two more
        depth = $urandom_range(14, 18);
        repeat (depth) drive_word({NIB_CALL, 12'($urandom_range(0, 4095))});
        repeat (depth + $urandom_range(0, 2)) drive_word(W_RET);
      end else if (pick < 93) begin
        w = UNIMPL_WORDS[$urandom_range(0, N_UNIMPL - 1)];
        if (w[15:12] != 4'h0) w[11:8] = x;
        drive_word(w);
      end else begin
        drive_word(16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register extremes, add wrap, skip both ways, index extremes
    drive_word({NIB_LD, 4'h0, 8'h00});
    drive_word({NIB_LD, 4'hF, 8'hFF});
    drive_word({NIB_ADD, 4'hF, 8'h01});
    drive_word({NIB_ADD, 4'hA, 8'hFF});
    drive_word({NIB_SE, 4'hF, 8'h00});
    drive_word({NIB_SE, 4'hA, 8'h00});
    drive_word({NIB_LDA, 12'h000});
    drive_word({NIB_LDA, 12'hFFF});
    // return on empty stack, then a call and its return
    drive_word(W_RET);
    drive_word({NIB_CALL, 12'hABC});
    drive_word(W_RET);
    foreach (EDGE_WORDS[i]) drive_word(EDGE_WORDS[i]);

    // pc wrap on plain advance, on a taken skip and on the pushed return address
    write_start(12'hFFE);
    drive_word({NIB_LD, 4'h1, 8'h80});
    write_start(12'hFFC);
    drive_word({NIB_SE, 4'h0, 8'h00});
    write_start(12'hFFE);
    drive_word({NIB_CALL, 12'hFFF});
    drive_word(W_RET);

    write_start(12'h000);
    run_random(RANDOM_ITEMS / 4);
    write_start(12'hFFF);
    run_random(RANDOM_ITEMS / 4);
    write_start(12'($urandom_range(0, 4095)));
    run_random(RANDOM_ITEMS / 4);
    write_start(START_RESET);
    run_random(RANDOM_ITEMS / 4);

    go_idle();
    repeat (8) @(posedge clk);

    $display("%0d instructions sent under %0d start address loads, %0d beats checked",
             items_sent, starts_written, sb.checked);
    $display("ok %0d, illegal %0d, underflow %0d, overflow %0d, not implemented %0d",
             sb.status_count[ST_OK], sb.status_count[ST_ILL], sb.status_count[ST_UF],
             sb.status_count[ST_OF], sb.status_count[ST_NI]);
    $display("%0d of %0d decode outcomes hit", $countones(sb.ops_seen), NUM_OPS + 1);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
